@@ sv/stt_pkg.sv @@
// Shared types, codes and character tables for the source text tokenizer.
package stt_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Bundle queue depth between scanner and emitter (power of two).
    localparam int QDEPTH = 2;

    localparam int NKW = 5;

    localparam logic [4:0] K_IDENT  = 5'd0;
    localparam logic [4:0] K_NUMBER = 5'd1;
    localparam logic [4:0] K_LET    = 5'd2;
    localparam logic [4:0] K_PLUS   = 5'd7;
    localparam logic [4:0] K_MINUS  = 5'd8;
    localparam logic [4:0] K_STAR   = 5'd9;
    localparam logic [4:0] K_SLASH  = 5'd10;
    localparam logic [4:0] K_EQUAL  = 5'd11;
    localparam logic [4:0] K_EQEQ   = 5'd12;
    localparam logic [4:0] K_GT     = 5'd13;
    localparam logic [4:0] K_LT     = 5'd14;
    localparam logic [4:0] K_LPAREN = 5'd15;
    localparam logic [4:0] K_RPAREN = 5'd16;
    localparam logic [4:0] K_LBRACE = 5'd17;
    localparam logic [4:0] K_RBRACE = 5'd18;
    localparam logic [4:0] K_SEMI   = 5'd19;
    localparam logic [4:0] K_EOF    = 5'd20;
    localparam logic [4:0] K_ERROR  = 5'd21;
    localparam logic [4:0] SYM_NONE = 5'd0;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_EQ  = "=";
    localparam logic [7:0] CH_US  = "_";

    localparam logic [7:0] KW_TEXT [NKW][8] = '{
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NKW] = '{3'd3, 3'd5, 3'd5, 3'd2, 3'd4};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_EQUAL,
        MODE_DISCARD
    } mode_t;

    typedef struct packed {
        logic [7:0]  bad;
        logic [15:0] length;
        logic [31:0] offset;
        logic [15:0] column;
        logic [15:0] line;
        logic [4:0]  kind;
    } token_t;

    typedef struct packed {
        logic [1:0]       count;
        token_t [2:0]     tok;
    } bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_NL;
    endfunction

    function automatic logic [4:0] symbol_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            ">":     k = K_GT;
            "<":     k = K_LT;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ";":     k = K_SEMI;
            default: k = SYM_NONE;
        endcase
        return k;
    endfunction

    // Keywords whose character at position pos equals c.
    function automatic logic [NKW-1:0] kw_hit(input logic big, input logic [2:0] pos,
                                               input logic [7:0] c);
        logic [NKW-1:0] m;
        for (int k = 0; k < NKW; k++) begin
            m[k] = !big && (pos < KW_LEN[k]) && (KW_TEXT[k][pos] == c);
        end
        return m;
    endfunction

    function automatic logic [4:0] close_kind(input mode_t mode, input logic [NKW-1:0] cand,
                                              input logic [NKW-1:0] eqlen);
        logic [4:0] kind;
        kind = K_IDENT;
        unique case (mode)
            MODE_IDENT: begin
                for (int k = 0; k < NKW; k++) begin
                    if (cand[k] && eqlen[k]) begin
                        kind = 5'(K_LET + 5'(k));
                    end
                end
            end
            MODE_NUMBER: kind = K_NUMBER;
            MODE_EQUAL:  kind = K_EQUAL;
            default:     kind = K_IDENT;
        endcase
        return kind;
    endfunction

endpackage

@@ sv/stt_scan.sv @@
// Front end: accepts bytes, tracks position and builds the token bundle of each transfer.
module stt_scan #(
    parameter int COUNT_BITS  = stt_pkg::COUNT_BITS_DEF,
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [7:0]       in_byte,
    input  logic             in_final,
    input  logic             in_nobyte,
    output logic             push,
    output stt_pkg::bundle_t push_bundle
);
    import stt_pkg::*;

    mode_t                  mode_reg, mode_next, mode_mid;
    logic [COUNT_BITS-1:0]  line_reg, line_next, line_mid;
    logic [COUNT_BITS-1:0]  col_reg, col_next, col_mid;
    logic [COUNT_BITS-1:0]  pcol_reg, pcol_next, pcol_mid;
    logic [COUNT_BITS-1:0]  plen_reg, plen_next, plen_mid;
    logic [OFFSET_BITS-1:0] off_reg, off_next, off_mid;
    logic [OFFSET_BITS-1:0] poff_reg, poff_next, poff_mid;
    logic [NKW-1:0]         cand_reg, cand_next, cand_mid;

    logic active, cont, close_a, eqeq_a, sym_a, err_a, close_b, eof_b;
    logic pos_big;
    logic [NKW-1:0] eqlen_reg, eqlen_mid;

    logic [COUNT_BITS+15:0]  line_rx, line_mx, col_rx, col_mx;
    logic [COUNT_BITS+15:0]  pcol_rx, pcol_mx, plen_rx, plen_mx;
    logic [OFFSET_BITS+31:0] off_rx, off_mx, poff_rx, poff_mx;

    token_t         ct [4];
    logic [3:0]     cv;
    bundle_t        bun;
    logic [1:0]     n;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Output fields carry the low bits of the counters.
    assign line_rx = {16'd0, line_reg};
    assign line_mx = {16'd0, line_mid};
    assign col_rx  = {16'd0, col_reg};
    assign col_mx  = {16'd0, col_mid};
    assign pcol_rx = {16'd0, pcol_reg};
    assign pcol_mx = {16'd0, pcol_mid};
    assign plen_rx = {16'd0, plen_reg};
    assign plen_mx = {16'd0, plen_mid};
    assign off_rx  = {32'd0, off_reg};
    assign off_mx  = {32'd0, off_mid};
    assign poff_rx = {32'd0, poff_reg};
    assign poff_mx = {32'd0, poff_mid};

    assign pos_big = plen_reg > COUNT_BITS'(7);

    always_comb begin
        for (int k = 0; k < NKW; k++) begin
            eqlen_reg[k] = plen_reg == COUNT_BITS'(KW_LEN[k]);
            eqlen_mid[k] = plen_mid == COUNT_BITS'(KW_LEN[k]);
        end
    end

    // Next state: byte handling first, then end of text.
    always_comb begin
        mode_mid = mode_reg;
        line_mid = line_reg;
        col_mid  = col_reg;
        off_mid  = off_reg;
        pcol_mid = pcol_reg;
        poff_mid = poff_reg;
        plen_mid = plen_reg;
        cand_mid = cand_reg;
        cont     = 1'b0;
        close_a  = 1'b0;
        eqeq_a   = 1'b0;
        sym_a    = 1'b0;
        err_a    = 1'b0;
        active   = !in_nobyte && mode_reg != MODE_DISCARD;

        if (active) begin
            unique case (mode_reg)
                MODE_IDENT: begin
                    if (is_letter(in_byte) || is_digit(in_byte)) begin
                        cont     = 1'b1;
                        cand_mid = cand_reg & kw_hit(pos_big, plen_reg[2:0], in_byte);
                        plen_mid = sat_inc(plen_reg);
                    end else begin
                        close_a = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(in_byte)) begin
                        cont     = 1'b1;
                        plen_mid = sat_inc(plen_reg);
                    end else begin
                        close_a = 1'b1;
                    end
                end
                MODE_EQUAL: begin
                    if (in_byte == CH_EQ) begin
                        cont     = 1'b1;
                        eqeq_a   = 1'b1;
                        mode_mid = MODE_IDLE;
                    end else begin
                        close_a = 1'b1;
                    end
                end
                default: ;
            endcase
            if (close_a) begin
                mode_mid = MODE_IDLE;
            end
            if (!cont) begin
                priority if (is_space(in_byte)) begin
                end else if (is_letter(in_byte) || is_digit(in_byte) || in_byte == CH_EQ) begin
                    mode_mid = is_letter(in_byte) ? MODE_IDENT :
                               is_digit(in_byte)  ? MODE_NUMBER : MODE_EQUAL;
                    pcol_mid = col_reg;
                    poff_mid = off_reg;
                    plen_mid = COUNT_BITS'(1);
                    cand_mid = kw_hit(1'b0, 3'd0, in_byte);
                end else if (symbol_kind(in_byte) != SYM_NONE) begin
                    sym_a = 1'b1;
                end else begin
                    err_a    = 1'b1;
                    mode_mid = MODE_DISCARD;
                end
            end
            // Advance the position past this byte.
            if (in_byte == CH_NL) begin
                line_mid = sat_inc(line_reg);
                col_mid  = COUNT_BITS'(1);
            end else begin
                col_mid = sat_inc(col_reg);
            end
            off_mid = off_reg + 1'b1;
        end

        close_b = in_final && (mode_mid == MODE_IDENT || mode_mid == MODE_NUMBER ||
                               mode_mid == MODE_EQUAL);
        eof_b   = in_final && mode_mid != MODE_DISCARD;

        if (in_final) begin
            mode_next = MODE_IDLE;
            line_next = COUNT_BITS'(1);
            col_next  = COUNT_BITS'(1);
            off_next  = '0;
            pcol_next = COUNT_BITS'(1);
            poff_next = '0;
            plen_next = '0;
            cand_next = '1;
        end else begin
            mode_next = mode_mid;
            line_next = line_mid;
            col_next  = col_mid;
            off_next  = off_mid;
            pcol_next = pcol_mid;
            poff_next = poff_mid;
            plen_next = plen_mid;
            cand_next = cand_mid;
        end
    end

    // Outputs: candidate tokens in model order, then packed into the bundle.
    always_comb begin
        ct[0].kind   = eqeq_a ? K_EQEQ : close_kind(mode_reg, cand_reg, eqlen_reg);
        ct[0].line   = line_rx[15:0];
        ct[0].column = pcol_rx[15:0];
        ct[0].offset = poff_rx[31:0];
        ct[0].length = eqeq_a ? 16'd2 : plen_rx[15:0];
        ct[0].bad    = 8'd0;
        cv[0]        = in_fire && (close_a || eqeq_a);

        ct[1].kind   = err_a ? K_ERROR : symbol_kind(in_byte);
        ct[1].line   = line_rx[15:0];
        ct[1].column = col_rx[15:0];
        ct[1].offset = off_rx[31:0];
        ct[1].length = 16'd1;
        ct[1].bad    = err_a ? in_byte : 8'd0;
        cv[1]        = in_fire && (sym_a || err_a);

        ct[2].kind   = close_kind(mode_mid, cand_mid, eqlen_mid);
        ct[2].line   = line_mx[15:0];
        ct[2].column = pcol_mx[15:0];
        ct[2].offset = poff_mx[31:0];
        ct[2].length = plen_mx[15:0];
        ct[2].bad    = 8'd0;
        cv[2]        = in_fire && close_b;

        ct[3].kind   = K_EOF;
        ct[3].line   = line_mx[15:0];
        ct[3].column = col_mx[15:0];
        ct[3].offset = off_mx[31:0];
        ct[3].length = 16'd0;
        ct[3].bad    = 8'd0;
        cv[3]        = in_fire && eof_b;

        // At most three of the four are ever set.
        bun = '0;
        n   = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i]) begin
                bun.tok[n] = ct[i];
                n          = n + 2'd1;
            end
        end
        bun.count = n;
    end

    assign push        = |cv;
    assign push_bundle = bun;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            line_reg <= COUNT_BITS'(1);
            col_reg  <= COUNT_BITS'(1);
            off_reg  <= '0;
            pcol_reg <= COUNT_BITS'(1);
            poff_reg <= '0;
            plen_reg <= '0;
            cand_reg <= '1;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
            pcol_reg <= pcol_next;
            poff_reg <= poff_next;
            plen_reg <= plen_next;
            cand_reg <= cand_next;
        end
    end

endmodule

@@ sv/stt_queue.sv @@
// Short queue of token bundles between the scanner and the emitter.
module stt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  stt_pkg::bundle_t push_bundle,
    input  logic             pop,
    output logic             q_valid,
    output logic             q_full,
    output stt_pkg::bundle_t q_bundle
);
    import stt_pkg::*;

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    bundle_t          mem_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg, rptr_reg;
    logic [QAW:0]     cnt_reg, cnt_next;

    assign q_valid  = cnt_reg != '0;
    assign q_full   = cnt_reg == (QAW+1)'(QDEPTH);
    assign q_bundle = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/stt_emit.sv @@
// Back end: holds one bundle and sends its tokens out one transfer at a time.
module stt_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  stt_pkg::bundle_t q_bundle,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [87:0]      m_tdata,
    output logic [4:0]       m_tuser,
    output logic             m_tlast
);
    import stt_pkg::*;

    bundle_t    bun_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       last, done;
    token_t     tok;

    assign tok      = bun_reg.tok[idx_reg];
    assign last     = idx_reg == bun_reg.count - 2'd1;
    assign done     = busy_reg && m_tready && last;
    assign pop      = q_valid && (!busy_reg || done);

    assign m_tvalid = busy_reg;
    assign m_tdata  = {tok.bad, tok.length, tok.offset, tok.column, tok.line};
    assign m_tuser  = tok.kind;
    assign m_tlast  = last;

    always_ff @(posedge aclk) begin
        if (pop) begin
            bun_reg <= q_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else if (pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg && m_tready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

@@ sv/source_text_tokenizer_core.sv @@
// Tokens pass through the bundle queue and the emitter's bundle register to m_.
// Throughput: one byte per cycle while s_tready is high; one token per cycle out
// while m_tready is high, so the tokens that a byte closes leave in turn, and the
// two-entry bundle queue sets how far input runs ahead before s_tready drops.
// Reset: aresetn low clears scan state to line 1 column 1, empties the queue.
module source_text_tokenizer_core #(
    parameter int COUNT_BITS  = stt_pkg::COUNT_BITS_DEF,
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // text_byte
    input  logic        s_tlast,  // is_final
    input  logic        s_tuser,  // no_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_line[15:0], token_column[31:16], lexeme_offset[63:32],
    // lexeme_length[79:64], offending_byte[87:80]
    output logic [87:0] m_tdata,
    output logic [4:0]  m_tuser,  // token_kind
    output logic        m_tlast   // run_end
);
    import stt_pkg::*;

    logic    in_fire, push, pop, q_valid, q_full;
    bundle_t push_bundle, q_bundle;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    stt_scan #(
        .COUNT_BITS  (COUNT_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_final    (s_tlast),
        .in_nobyte   (s_tuser),
        .push        (push),
        .push_bundle (push_bundle)
    );

    stt_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .q_valid     (q_valid),
        .q_full      (q_full),
        .q_bundle    (q_bundle)
    );

    stt_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_bundle (q_bundle),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
